### hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Status codes, the command bundle broadcast along the cell chain, and the
// default queue depth.
// ----------------------------------------------------------------------------
package spq_pkg;

    // Default number of cells in the chain
    localparam int DEPTH_DEF = 16;

    // Field widths fixed by the interface
    localparam int VALUE_W  = 32;
    localparam int OCC_W    = 5;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_OVER  = 2'd1,
        ST_UNDER = 2'd2
    } t_status;

    // Input action codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    // Command broadcast to every cell
    typedef struct packed {
        logic                       ins;    // insert value in order
        logic                       rem;    // drop the head, shift down
        logic signed [VALUE_W-1:0]  value;  // value being inserted
    } t_cmd;

endpackage

### hdl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry. On insert it keeps its entry, takes the new value, or takes
// its lower neighbor's entry; on remove it takes its upper neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
(
    input  logic                       i_clk,
    input  t_cmd                       i_cmd,
    input  logic                       i_valid,        // slot is below the count
    input  logic signed [VALUE_W-1:0]  i_prev_entry,   // entry of lower neighbor
    input  logic                       i_prev_greater, // lower neighbor > value
    input  logic signed [VALUE_W-1:0]  i_next_entry,   // entry of upper neighbor
    output logic signed [VALUE_W-1:0]  o_entry,
    output logic                       o_greater
);

    logic signed [VALUE_W-1:0] r_entry;
    logic signed [VALUE_W-1:0] n_entry;

    // Strictly greater keeps equal values in arrival order
    assign o_greater = i_valid && (r_entry > i_cmd.value);
    assign o_entry   = r_entry;

    // Next entry selection
    always_comb begin
        n_entry = r_entry;
        if (i_cmd.rem) begin
            n_entry = i_next_entry;
        end else if (i_cmd.ins) begin
            if (i_prev_greater) begin
                n_entry = i_prev_entry;
            end else if (o_greater || !i_valid) begin
                n_entry = i_cmd.value;
            end
        end
    end

    // Entry register, payload only
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

### hdl/sorted_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit: sorted-array priority queue on a chain of cells
// Keeps up to DEPTH signed values in ascending order; insert places a value
// after equal entries, remove returns the smallest entry.
//
//   channel   direction  handshake          payload
//   command   in         start / busy       i_action, i_value
//   result    out        o_strobe (1 cyc)   o_removed_value, o_status, o_occupancy
//
// One transaction is accepted every cycle; busy stays low. All cells compare
// against the broadcast value and shift in the same cycle. The registered result
// reaches the result ports in the cycle after acceptance, strobed for one cycle.
// Synchronous active-low reset empties the queue and clears the strobe.
// The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_action,
    input  logic signed [VALUE_W-1:0]  i_value,
    output logic                       o_strobe,
    output logic signed [VALUE_W-1:0]  o_removed_value,
    output logic [1:0]                 o_status,
    output logic [OCC_W-1:0]           o_occupancy
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    logic                      w_accept;
    logic                      w_full;
    logic                      w_empty;
    t_cmd                      w_cmd;
    t_status                   w_status;

    logic signed [VALUE_W-1:0] w_entry   [DEPTH];
    logic                      w_greater [DEPTH];

    logic                      r_strobe;
    logic signed [VALUE_W-1:0] r_removed_value;
    t_status                   r_status;
    logic [OCC_W-1:0]          r_occupancy;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_full   = (r_count == FULL_CNT);
    assign w_empty  = (r_count == '0);

    // Command broadcast to the chain
    always_comb begin
        w_cmd.ins   = w_accept && (i_action == ACT_INSERT) && !w_full;
        w_cmd.rem   = w_accept && (i_action == ACT_REMOVE) && !w_empty;
        w_cmd.value = i_value;
    end

    // Cell chain
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [VALUE_W-1:0] w_prev_entry;
        logic                      w_prev_greater;
        logic signed [VALUE_W-1:0] w_next_entry;

        if (g == 0) begin : g_head
            assign w_prev_entry   = '0;
            assign w_prev_greater = 1'b0;
        end else begin : g_body
            assign w_prev_entry   = w_entry[g-1];
            assign w_prev_greater = w_greater[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_next_entry = '0;
        end else begin : g_link
            assign w_next_entry = w_entry[g+1];
        end

        spq_cell u_cell (
            .i_clk          (i_clk),
            .i_cmd          (w_cmd),
            .i_valid        (CNT_W'(g) < r_count),
            .i_prev_entry   (w_prev_entry),
            .i_prev_greater (w_prev_greater),
            .i_next_entry   (w_next_entry),
            .o_entry        (w_entry[g]),
            .o_greater      (w_greater[g])
        );
    end

    // Count update and status
    always_comb begin
        n_count  = r_count;
        w_status = ST_OK;
        if (w_cmd.ins) begin
            n_count = r_count + 1'b1;
        end else if (w_cmd.rem) begin
            n_count = r_count - 1'b1;
        end
        if (i_action == ACT_INSERT) begin
            if (w_full) w_status = ST_OVER;
        end else begin
            if (w_empty) w_status = ST_UNDER;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_strobe <= w_accept;
        end
    end

    // Result registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_removed_value <= w_cmd.rem ? w_entry[0] : '0;
            r_status        <= w_status;
            r_occupancy     <= OCC_W'(n_count);
        end
    end

    assign o_strobe        = r_strobe;
    assign o_removed_value = r_removed_value;
    assign o_status        = r_status;
    assign o_occupancy     = r_occupancy;

endmodule

### bench/tb_sorted_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue_unit: self-checking bench for the sorted queue
// Drives insert and remove commands through the start/busy handshake, keeps
// its own sorted copy of the queue to predict every result transaction, and
// compares each strobed result field by field. A directed pass covers the
// value extremes, equal values, underflow and overflow; random phases then
// fill, drain and churn the queue with random sender gaps.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue_unit;
    import spq_pkg::*;

    localparam int N_RANDOM   = 1500;
    localparam int QUIET_TAIL = 200;     // last items are sent back to back
    localparam int DRAIN_MAX  = 1000;    // cycle bound while waiting on results
    localparam int MAX_PRINTS = 40;

    // Expected result of one command transaction
    typedef struct {
        logic signed [VALUE_W-1:0] removed;
        t_status                   status;
        logic [OCC_W-1:0]          occ;
    } t_queue_result;

    // ------------------------------------------------------------------------
    // Scoreboard: sorted shadow of the queue plus the expected-result FIFO
    // ------------------------------------------------------------------------
    class queue_checker;
        logic signed [VALUE_W-1:0] sorted_vals[DEPTH_DEF];
        int                        held;
        t_queue_result             expected_results[$];
        int unsigned errors, checked, inserts, removes, overflows, underflows;

        function new();
            held   = 0;
            errors = 0;
            checked = 0;
            inserts = 0;
            removes = 0;
            overflows = 0;
            underflows = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Apply one accepted command to the shadow queue, queue its result
        function void note_command(logic action, logic signed [VALUE_W-1:0] value);
            t_queue_result r;
            int pos;
            int i;
            r.removed = '0;
            r.status  = ST_OK;
            if (action == ACT_INSERT) begin
                if (held >= DEPTH_DEF) begin
                    r.status = ST_OVER;
                    overflows++;
                end else begin
                    // equal entries stay ahead of the new value
                    pos = 0;
                    while (pos < held && sorted_vals[pos] <= value) pos++;
                    for (i = held; i > pos; i--) sorted_vals[i] = sorted_vals[i-1];
                    sorted_vals[pos] = value;
                    held++;
                    inserts++;
                end
            end else begin
                if (held == 0) begin
                    r.status = ST_UNDER;
                    underflows++;
                end else begin
                    r.removed = sorted_vals[0];
                    for (i = 1; i < held; i++) sorted_vals[i-1] = sorted_vals[i];
                    held--;
                    removes++;
                end
            end
            r.occ = held[OCC_W-1:0];
            expected_results.push_back(r);
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        // Compare one strobed result with the oldest expectation
        task check_result(logic signed [VALUE_W-1:0] removed, logic [1:0] status,
                          logic [OCC_W-1:0] occ);
            t_queue_result r;
            if (expected_results.size() == 0) begin
                report($sformatf("unexpected result removed=%0d status=%0d occ=%0d",
                                 removed, status, occ));
                return;
            end
            r = expected_results.pop_front();
            checked++;
            if (removed !== r.removed)
                report($sformatf("removed_value %0d, expected %0d", removed, r.removed));
            if (status !== r.status)
                report($sformatf("status %0d, expected %0d", status, r.status));
            if (occ !== r.occ)
                report($sformatf("occupancy %0d, expected %0d", occ, r.occ));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                      i_clk;
    logic                      i_rst_n  = 1'b0;
    logic                      start    = 1'b0;
    logic                      busy;
    logic                      i_action = ACT_INSERT;
    logic signed [VALUE_W-1:0] i_value  = '0;
    logic                      o_strobe;
    logic signed [VALUE_W-1:0] o_removed_value;
    logic [1:0]                o_status;
    logic [OCC_W-1:0]          o_occupancy;

    queue_checker chk = new();

    sorted_priority_queue_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_action        (i_action),
        .i_value         (i_value),
        .o_strobe        (o_strobe),
        .o_removed_value (o_removed_value),
        .o_status        (o_status),
        .o_occupancy     (o_occupancy)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop
    initial begin
        #2_000_000;
        $display("tb_sorted_priority_queue_unit: FAIL");
        $finish;
    end

    // Monitor: note accepted commands first, then check the strobed result
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && busy === 1'b0) chk.note_command(i_action, i_value);
            if (o_strobe !== 1'b0)
                chk.check_result(o_removed_value, o_status, o_occupancy);
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks (called and returning on a rising edge)
    // ------------------------------------------------------------------------
    task automatic send(logic action, logic signed [VALUE_W-1:0] value);
        i_action <= action;
        i_value  <= value;
        start    <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic idle(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Hold off until every queued expectation has been matched or DRAIN_MAX runs out
    task automatic wait_drained();
        int guard;
        guard = 0;
        start <= 1'b0;
        do begin
            @(negedge i_clk);
            guard++;
        end while (chk.pending() != 0 && guard < DRAIN_MAX);
        @(posedge i_clk);
    endtask

    // Value mix: extremes, a narrow band for duplicates, or fully random
    function automatic logic signed [VALUE_W-1:0] pick_value();
        logic signed [VALUE_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1: begin
                case ($urandom_range(0, 5))
                    0: v = 32'sh8000_0000;
                    1: v = 32'sh8000_0001;
                    2: v = 32'sh7FFF_FFFF;
                    3: v = 32'sh7FFF_FFFE;
                    4: v = '0;
                    default: v = -1;
                endcase
            end
            2, 3, 4: v = $signed($urandom_range(0, 8)) - 4;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Directed pass: underflow, extremes, equal values, fill to overflow
    task automatic run_directed();
        int k;
        send(ACT_REMOVE, $urandom);
        send(ACT_INSERT, 32'sh7FFF_FFFF);
        send(ACT_INSERT, 32'sh8000_0000);
        send(ACT_INSERT, 0);
        send(ACT_INSERT, -1);
        send(ACT_INSERT, 5);
        send(ACT_INSERT, 5);
        send(ACT_REMOVE, 32'sh7FFF_FFFF);
        send(ACT_REMOVE, 0);
        send(ACT_REMOVE, $urandom);
        // descending values land below the earlier ones and shift those cells up
        for (k = 0; k < 13; k++) send(ACT_INSERT, 1000 - k * 7);
        send(ACT_INSERT, 32'sh8000_0000);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int n;
        int phase_left;
        int ins_weight;
        logic action;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        wait_drained();

        phase_left = 0;
        ins_weight = 50;
        for (n = 0; n < N_RANDOM; n++) begin
            // new phase: fill, drain or churn
            if (phase_left == 0) begin
                phase_left = $urandom_range(20, 60);
                case ($urandom_range(0, 2))
                    0: ins_weight = 85;
                    1: ins_weight = 15;
                    default: ins_weight = 50;
                endcase
            end
            phase_left--;
            action = ($urandom_range(1, 100) <= ins_weight) ? ACT_INSERT : ACT_REMOVE;
            send(action, pick_value());
            if (n < N_RANDOM - QUIET_TAIL) begin
                if ($urandom_range(0, 99) == 0)
                    wait_drained();
                else if ($urandom_range(0, 3) == 0)
                    idle($urandom_range(1, 5));
            end
        end

        wait_drained();
        repeat (4) @(posedge i_clk);
        while (chk.pending() != 0) begin
            void'(chk.expected_results.pop_front());
            chk.report("expected result never arrived");
        end

        $display("Checked %0d results: %0d inserts, %0d removes, %0d overflows, %0d underflows.",
                 chk.checked, chk.inserts, chk.removes, chk.overflows, chk.underflows);
        $display("Mismatches: %0d", chk.errors);
        if (chk.errors == 0)
            $display("tb_sorted_priority_queue_unit: PASS");
        else
            $display("tb_sorted_priority_queue_unit: FAIL");
        $finish;
    end

endmodule
